// ----- hw/rtl/flas_pkg.sv -----
// Shared types, register indexes and datapath operation codes for the alignment steering block.
`timescale 1ns / 1ps

package flas_pkg;

  // Configuration port geometry and register indexes.
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;
  localparam logic [CFG_IDX_W-1:0] REG_ALIGN_GAIN       = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_NEIGHBOUR_RADIUS = 2'd1;

  // Register reset values: gain 1.0 in Q8.8, radius 10.0 in Q16.16.
  localparam logic [15:0] GAIN_RESET   = 16'd256;
  localparam logic [30:0] RADIUS_RESET = 31'd655360;

  // Item command codes.
  localparam logic CMD_BEGIN     = 1'b0;
  localparam logic CMD_NEIGHBOUR = 1'b1;

  // Largest Q1.15 direction component.
  localparam logic [15:0] DIR_MAX = 16'd32767;

  // Input item.
  typedef struct packed {
    logic               cmd;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic signed [31:0] vel_x;
    logic signed [31:0] vel_y;
    logic signed [31:0] vel_z;
    logic [30:0]        speed_limit;
    logic               is_self;
    logic               last;
  } in_t;

  // Result item.
  typedef struct packed {
    logic signed [31:0] steer_x;
    logic signed [31:0] steer_y;
    logic signed [31:0] steer_z;
    logic signed [15:0] dir_x;
    logic signed [15:0] dir_y;
    logic signed [15:0] dir_z;
  } out_t;

  // Datapath micro-operations issued by the controller.
  typedef enum logic [4:0] {
    OP_NONE,
    OP_LOAD,
    OP_BEGIN,
    OP_DIST,
    OP_DMUL,
    OP_DACC,
    OP_UPD,
    OP_QML,
    OP_QAL,
    OP_QMH,
    OP_QAH,
    OP_QDIV_GO,
    OP_QDIV_END,
    OP_NINIT,
    OP_NSHIFT,
    OP_SQM,
    OP_SQA,
    OP_SQRT_GO,
    OP_SQRT_END,
    OP_LMUL,
    OP_LCMP,
    OP_DDIV_GO,
    OP_DSET,
    OP_SMUL,
    OP_SDIV_GO,
    OP_SSET,
    OP_OUT
  } op_t;

  // Command from controller to datapath.
  typedef struct packed {
    op_t        op;
    logic [1:0] idx;
  } dp_cmd_t;

  // Status from datapath to controller.
  typedef struct packed {
    logic in_cmd;
    logic in_self;
    logic in_last;
    logic div_done;
    logic sqrt_done;
    logic m_big;
    logic mg_zero;
    logic clamp;
    logic out_free;
  } dp_status_t;

endpackage

// ----- hw/rtl/flock_alignment_steer.sv -----
// Top level of the flocking alignment steering block.
`timescale 1ns / 1ps

// Takes one item at a time. A begin item or a skipped neighbour is only loaded and decoded,
// and a tested neighbour adds the distance magnitudes, then four squares through the one
// shared 32x32 multiplier, then the update. An item with last set adds the result
// computation: three scaling divides and up to six direction and clamp divides in the
// shared divider, a square root and a normalizing shift. A finished result waits in the
// output register while the next item is accepted; only the next result waits for its
// transfer. Register writes are taken in any cycle outside reset and belong between
// queries, when no item is in flight.
module flock_alignment_steer #(
  parameter int MAX_NEIGHBOURS = 256
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  flas_pkg::in_t                    in_data,
  output logic                             out_valid,
  input  logic                             out_ready,
  output flas_pkg::out_t                   out_data,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [flas_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [flas_pkg::CFG_DATA_W-1:0]  cfg_data
);

  flas_pkg::dp_cmd_t    cmd;
  flas_pkg::dp_status_t status;

  // Register writes are taken in any cycle outside reset.
  assign cfg_ready = !rst;

  flas_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  flas_dp #(
    .MAX_NEIGHBOURS (MAX_NEIGHBOURS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .status    (status),
    .in_data   (in_data),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

// ----- hw/rtl/flas_div.sv -----
// Restoring divider, 64-bit dividend by 32-bit divisor, one quotient bit per cycle.
`timescale 1ns / 1ps

module flas_div (
  input  logic        clk,
  input  logic        rst,
  input  logic        go,
  input  logic [63:0] dividend,
  input  logic [31:0] divisor,
  output logic [63:0] quot,
  output logic        done
);

  localparam int NBITS = 64;
  localparam int CNT_W = $clog2(NBITS);

  logic [31:0]      rem;
  logic [63:0]      quo;
  logic [31:0]      dvs;
  logic [CNT_W-1:0] cnt;
  logic             busy;
  logic [32:0]      trial;
  logic             fits;

  // One trial subtraction per cycle.
  assign trial = {rem, quo[63]};
  assign fits  = trial >= {1'b0, dvs};
  assign quot  = quo;

  // Control: iteration count and completion pulse.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (go) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(NBITS - 1);
      end else if (busy) begin
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          cnt <= cnt - 1'b1;
        end
      end
    end
  end

  // Remainder and quotient shift register.
  always_ff @(posedge clk) begin
    if (go) begin
      rem <= '0;
      quo <= dividend;
      dvs <= divisor;
    end else if (busy) begin
      rem <= fits ? 32'(trial - {1'b0, dvs}) : trial[31:0];
      quo <= {quo[62:0], fits};
    end
  end

endmodule

// ----- hw/rtl/flas_sqrt.sv -----
// Bit-pair integer square root of a 64-bit value, one result bit per cycle.
`timescale 1ns / 1ps

module flas_sqrt (
  input  logic        clk,
  input  logic        rst,
  input  logic        go,
  input  logic [63:0] n,
  output logic [31:0] root,
  output logic        done
);

  localparam logic [63:0] TOP_BIT = 64'h4000_0000_0000_0000;

  logic [63:0] nrem;
  logic [63:0] res;
  logic [63:0] bitv;
  logic        busy;
  logic [63:0] trial;

  assign trial = res + bitv;
  assign root  = res[31:0];

  // Control: runs until the probe bit has passed bit zero.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (go) begin
        busy <= 1'b1;
      end else if (busy && bitv[0]) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  // Remainder, partial root and probe bit.
  always_ff @(posedge clk) begin
    if (go) begin
      nrem <= n;
      res  <= '0;
      bitv <= TOP_BIT;
    end else if (busy) begin
      if (nrem >= trial) begin
        nrem <= nrem - trial;
        res  <= (res >> 1) + bitv;
      end else begin
        res <= res >> 1;
      end
      bitv <= bitv >> 2;
    end
  end

endmodule

// ----- hw/rtl/flas_dp.sv -----
// Datapath: agent state, sums, shared multiplier, divider and square root, result register.
`timescale 1ns / 1ps

module flas_dp #(
  parameter int MAX_NEIGHBOURS = 256
) (
  input  logic                             clk,
  input  logic                             rst,
  input  flas_pkg::dp_cmd_t                cmd,
  output flas_pkg::dp_status_t             status,
  input  flas_pkg::in_t                    in_data,
  input  logic                             cfg_valid,
  input  logic [flas_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [flas_pkg::CFG_DATA_W-1:0]  cfg_data,
  output logic                             out_valid,
  input  logic                             out_ready,
  output flas_pkg::out_t                   out_data
);

  localparam int CW = $clog2(MAX_NEIGHBOURS + 1);
  localparam int SW = 32 + CW;

  // Configuration registers.
  logic [15:0] align_gain;
  logic [30:0] neighbour_radius;

  // Agent state.
  flas_pkg::in_t          item;
  logic signed [31:0]     own_pos [3];
  logic [30:0]            own_limit;
  logic signed [SW-1:0]   vel_sum [3];
  logic [CW-1:0]          near_count;

  // Working registers.
  logic [31:0] ad [3];
  logic        near;
  logic [63:0] d2;
  logic [63:0] rr;
  logic [63:0] prod;
  logic [63:0] acc;
  logic [63:0] q [3];
  logic [63:0] uw [3];
  logic [63:0] m;
  logic        over_m;
  logic        over;
  logic [63:0] n2;
  logic [31:0] mg;
  logic [31:0] res_steer [3];
  logic [15:0] res_dir [3];

  // Combinational helpers.
  logic signed [31:0] pos_in [3];
  logic signed [31:0] vel_in [3];
  logic [31:0]        ad_c [3];
  logic [SW-1:0]      abs_sum;
  logic               neg_cur;
  logic [31:0]        u_cur;
  logic [31:0]        mul_a;
  logic [31:0]        mul_b;
  logic [63:0]        mul_p;
  logic               div_go;
  logic [63:0]        div_dividend;
  logic [31:0]        div_divisor;
  logic [63:0]        div_quot;
  logic               div_done;
  logic               sqrt_go;
  logic [31:0]        sqrt_root;
  logic               sqrt_done;
  logic [15:0]        dmag;
  logic [31:0]        smag;
  logic               clamp;
  logic               out_free;
  logic               may_add;

  assign pos_in[0] = item.pos_x;
  assign pos_in[1] = item.pos_y;
  assign pos_in[2] = item.pos_z;
  assign vel_in[0] = item.vel_x;
  assign vel_in[1] = item.vel_y;
  assign vel_in[2] = item.vel_z;

  // Per-axis distance magnitude between own and neighbour position.
  always_comb begin
    logic signed [32:0] diff;
    for (int i = 0; i < 3; i++) begin
      diff    = {own_pos[i][31], own_pos[i]} - {pos_in[i][31], pos_in[i]};
      ad_c[i] = diff[32] ? 32'(-diff) : diff[31:0];
    end
  end

  // Magnitude and sign of the selected velocity sum.
  assign neg_cur = vel_sum[cmd.idx][SW-1];
  assign abs_sum = neg_cur ? SW'(-vel_sum[cmd.idx]) : vel_sum[cmd.idx];
  assign u_cur   = uw[cmd.idx][31:0];

  // Operand selection for the shared multiplier.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd.op)
      flas_pkg::OP_DMUL: begin
        if (cmd.idx == 2'd3) begin
          mul_a = {1'b0, neighbour_radius};
          mul_b = {1'b0, neighbour_radius};
        end else begin
          mul_a = ad[cmd.idx];
          mul_b = ad[cmd.idx];
        end
      end
      flas_pkg::OP_QML: begin
        mul_a = abs_sum[31:0];
        mul_b = {16'b0, align_gain};
      end
      flas_pkg::OP_QMH: begin
        mul_a = 32'(abs_sum[SW-1:32]);
        mul_b = {16'b0, align_gain};
      end
      flas_pkg::OP_SQM: begin
        mul_a = u_cur;
        mul_b = u_cur;
      end
      flas_pkg::OP_LMUL: begin
        mul_a = {1'b0, own_limit};
        mul_b = {1'b0, own_limit};
      end
      flas_pkg::OP_SMUL: begin
        mul_a = u_cur;
        mul_b = {1'b0, own_limit};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_p = {32'b0, mul_a} * {32'b0, mul_b};

  // Divider request selection.
  always_comb begin
    div_go       = 1'b0;
    div_dividend = '0;
    div_divisor  = '0;
    case (cmd.op)
      flas_pkg::OP_QDIV_GO: begin
        div_go       = 1'b1;
        div_dividend = acc >> 8;
        div_divisor  = 32'(near_count) + 32'd1;
      end
      flas_pkg::OP_DDIV_GO: begin
        div_go       = 1'b1;
        div_dividend = {32'b0, u_cur} << 15;
        div_divisor  = mg;
      end
      flas_pkg::OP_SDIV_GO: begin
        div_go       = 1'b1;
        div_dividend = prod;
        div_divisor  = mg;
      end
      default: begin
        div_go = 1'b0;
      end
    endcase
  end

  assign sqrt_go = (cmd.op == flas_pkg::OP_SQRT_GO);

  flas_div u_div (
    .clk      (clk),
    .rst      (rst),
    .go       (div_go),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .quot     (div_quot),
    .done     (div_done)
  );

  flas_sqrt u_sqrt (
    .clk  (clk),
    .rst  (rst),
    .go   (sqrt_go),
    .n    (n2),
    .root (sqrt_root),
    .done (sqrt_done)
  );

  // Direction and steer magnitudes for the component being finished.
  assign clamp    = over && (mg != '0);
  assign dmag     = (mg == '0) ? 16'd0 :
                    (div_quot > 64'(flas_pkg::DIR_MAX)) ? flas_pkg::DIR_MAX : div_quot[15:0];
  assign smag     = clamp ? div_quot[31:0] : (over ? 32'd0 : q[cmd.idx][31:0]);
  assign out_free = !out_valid || out_ready;
  assign may_add  = near && (d2 <= rr) && (near_count < CW'(MAX_NEIGHBOURS));

  // Status back to the controller.
  always_comb begin
    status.in_cmd    = item.cmd;
    status.in_self   = item.is_self;
    status.in_last   = item.last;
    status.div_done  = div_done;
    status.sqrt_done = sqrt_done;
    status.m_big     = |m[63:31];
    status.mg_zero   = (mg == '0);
    status.clamp     = clamp;
    status.out_free  = out_free;
  end

  // Configuration and agent state, visible across items.
  always_ff @(posedge clk) begin
    if (rst) begin
      align_gain       <= flas_pkg::GAIN_RESET;
      neighbour_radius <= flas_pkg::RADIUS_RESET;
      own_limit        <= '0;
      near_count       <= '0;
      for (int i = 0; i < 3; i++) begin
        own_pos[i] <= '0;
        vel_sum[i] <= '0;
      end
    end else begin
      if (cfg_valid) begin
        case (cfg_index)
          flas_pkg::REG_ALIGN_GAIN:       align_gain       <= cfg_data[15:0];
          flas_pkg::REG_NEIGHBOUR_RADIUS: neighbour_radius <= cfg_data[30:0];
          default: begin
          end
        endcase
      end
      if (cmd.op == flas_pkg::OP_BEGIN) begin
        own_limit  <= item.speed_limit;
        near_count <= '0;
        for (int i = 0; i < 3; i++) begin
          own_pos[i] <= pos_in[i];
          vel_sum[i] <= '0;
        end
      end else if (cmd.op == flas_pkg::OP_UPD && may_add) begin
        near_count <= near_count + 1'b1;
        for (int i = 0; i < 3; i++) begin
          vel_sum[i] <= vel_sum[i] + SW'(vel_in[i]);
        end
      end
    end
  end

  // Working registers of the neighbour test and the result computation.
  always_ff @(posedge clk) begin
    case (cmd.op)
      flas_pkg::OP_LOAD: item <= in_data;
      flas_pkg::OP_DIST: begin
        for (int i = 0; i < 3; i++) ad[i] <= ad_c[i];
        near <= (ad_c[0] <= {1'b0, neighbour_radius}) &&
                (ad_c[1] <= {1'b0, neighbour_radius}) &&
                (ad_c[2] <= {1'b0, neighbour_radius});
      end
      flas_pkg::OP_DMUL: prod <= mul_p;
      flas_pkg::OP_DACC: begin
        if (cmd.idx == 2'd3) rr <= prod;
        else if (cmd.idx == 2'd0) d2 <= prod;
        else d2 <= d2 + prod;
      end
      flas_pkg::OP_QML: begin
        prod <= mul_p;
        if (cmd.idx == 2'd0) m <= '0;
      end
      flas_pkg::OP_QAL: acc <= prod;
      flas_pkg::OP_QMH: prod <= mul_p;
      flas_pkg::OP_QAH: acc <= acc + (prod << 32);
      flas_pkg::OP_QDIV_END: begin
        q[cmd.idx] <= div_quot;
        if (div_quot > m) m <= div_quot;
      end
      flas_pkg::OP_NINIT: begin
        for (int i = 0; i < 3; i++) uw[i] <= q[i];
        over_m <= m > {33'b0, own_limit};
      end
      flas_pkg::OP_NSHIFT: begin
        m <= m >> 1;
        for (int i = 0; i < 3; i++) uw[i] <= uw[i] >> 1;
      end
      flas_pkg::OP_SQM: prod <= mul_p;
      flas_pkg::OP_SQA: begin
        if (cmd.idx == 2'd0) n2 <= prod;
        else n2 <= n2 + prod;
      end
      flas_pkg::OP_SQRT_END: mg <= sqrt_root;
      flas_pkg::OP_LMUL: prod <= mul_p;
      flas_pkg::OP_LCMP: over <= over_m || (n2 > prod);
      flas_pkg::OP_DSET: res_dir[cmd.idx] <= neg_cur ? 16'(-dmag) : dmag;
      flas_pkg::OP_SMUL: prod <= mul_p;
      flas_pkg::OP_SSET: res_steer[cmd.idx] <= neg_cur ? 32'(-smag) : smag;
      default: begin
      end
    endcase
  end

  // Output register: holds a finished result until its transfer.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.op == flas_pkg::OP_OUT) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.op == flas_pkg::OP_OUT) begin
      out_data.steer_x <= res_steer[0];
      out_data.steer_y <= res_steer[1];
      out_data.steer_z <= res_steer[2];
      out_data.dir_x   <= res_dir[0];
      out_data.dir_y   <= res_dir[1];
      out_data.dir_z   <= res_dir[2];
    end
  end

endmodule

// ----- hw/rtl/flas_ctrl.sv -----
// Controller: sequences the datapath through the neighbour test and the result computation.
`timescale 1ns / 1ps

module flas_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  flas_pkg::dp_status_t status,
  output flas_pkg::dp_cmd_t    cmd
);

  typedef enum logic [21:0] {
    S_IDLE   = 22'h000001,
    S_DECODE = 22'h000002,
    S_DIST   = 22'h000004,
    S_DMUL   = 22'h000008,
    S_DACC   = 22'h000010,
    S_UPD    = 22'h000020,
    S_QMLO   = 22'h000040,
    S_QALO   = 22'h000080,
    S_QMHI   = 22'h000100,
    S_QAHI   = 22'h000200,
    S_QDIV   = 22'h000400,
    S_NINIT  = 22'h000800,
    S_NORM   = 22'h001000,
    S_SQMUL  = 22'h002000,
    S_SQACC  = 22'h004000,
    S_SQRT   = 22'h008000,
    S_LMUL   = 22'h010000,
    S_LCMP   = 22'h020000,
    S_DDIV   = 22'h040000,
    S_SMUL   = 22'h080000,
    S_SDIV   = 22'h100000,
    S_OUT    = 22'h200000
  } state_t;

  state_t     state, state_next;
  logic [1:0] idx, idx_next;
  logic       waiting, waiting_next;

  // No transfer is taken while reset is held.
  assign in_ready = (state == S_IDLE) && !rst;

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      idx     <= '0;
      waiting <= 1'b0;
    end else begin
      state   <= state_next;
      idx     <= idx_next;
      waiting <= waiting_next;
    end
  end

  // Next state and datapath command.
  always_comb begin
    state_next   = state;
    idx_next     = idx;
    waiting_next = waiting;
    cmd.op       = flas_pkg::OP_NONE;
    cmd.idx      = idx;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.op     = flas_pkg::OP_LOAD;
          state_next = S_DECODE;
        end
      end
      S_DECODE: begin
        idx_next = '0;
        if (status.in_cmd == flas_pkg::CMD_BEGIN) begin
          cmd.op     = flas_pkg::OP_BEGIN;
          state_next = status.in_last ? S_QMLO : S_IDLE;
        end else if (status.in_self) begin
          state_next = status.in_last ? S_QMLO : S_IDLE;
        end else begin
          state_next = S_DIST;
        end
      end
      S_DIST: begin
        cmd.op     = flas_pkg::OP_DIST;
        state_next = S_DMUL;
      end
      S_DMUL: begin
        cmd.op     = flas_pkg::OP_DMUL;
        state_next = S_DACC;
      end
      S_DACC: begin
        cmd.op = flas_pkg::OP_DACC;
        if (idx == 2'd3) begin
          state_next = S_UPD;
        end else begin
          idx_next   = idx + 1'b1;
          state_next = S_DMUL;
        end
      end
      S_UPD: begin
        cmd.op     = flas_pkg::OP_UPD;
        idx_next   = '0;
        state_next = status.in_last ? S_QMLO : S_IDLE;
      end
      S_QMLO: begin
        cmd.op     = flas_pkg::OP_QML;
        state_next = S_QALO;
      end
      S_QALO: begin
        cmd.op     = flas_pkg::OP_QAL;
        state_next = S_QMHI;
      end
      S_QMHI: begin
        cmd.op     = flas_pkg::OP_QMH;
        state_next = S_QAHI;
      end
      S_QAHI: begin
        cmd.op     = flas_pkg::OP_QAH;
        state_next = S_QDIV;
      end
      S_QDIV: begin
        if (!waiting) begin
          cmd.op       = flas_pkg::OP_QDIV_GO;
          waiting_next = 1'b1;
        end else if (status.div_done) begin
          cmd.op       = flas_pkg::OP_QDIV_END;
          waiting_next = 1'b0;
          if (idx == 2'd2) begin
            idx_next   = '0;
            state_next = S_NINIT;
          end else begin
            idx_next   = idx + 1'b1;
            state_next = S_QMLO;
          end
        end
      end
      S_NINIT: begin
        cmd.op     = flas_pkg::OP_NINIT;
        state_next = S_NORM;
      end
      S_NORM: begin
        if (status.m_big) begin
          cmd.op = flas_pkg::OP_NSHIFT;
        end else begin
          idx_next   = '0;
          state_next = S_SQMUL;
        end
      end
      S_SQMUL: begin
        cmd.op     = flas_pkg::OP_SQM;
        state_next = S_SQACC;
      end
      S_SQACC: begin
        cmd.op = flas_pkg::OP_SQA;
        if (idx == 2'd2) begin
          idx_next   = '0;
          state_next = S_SQRT;
        end else begin
          idx_next   = idx + 1'b1;
          state_next = S_SQMUL;
        end
      end
      S_SQRT: begin
        if (!waiting) begin
          cmd.op       = flas_pkg::OP_SQRT_GO;
          waiting_next = 1'b1;
        end else if (status.sqrt_done) begin
          cmd.op       = flas_pkg::OP_SQRT_END;
          waiting_next = 1'b0;
          state_next   = S_LMUL;
        end
      end
      S_LMUL: begin
        cmd.op     = flas_pkg::OP_LMUL;
        state_next = S_LCMP;
      end
      S_LCMP: begin
        cmd.op     = flas_pkg::OP_LCMP;
        idx_next   = '0;
        state_next = S_DDIV;
      end
      S_DDIV: begin
        if (status.mg_zero) begin
          cmd.op     = flas_pkg::OP_DSET;
          state_next = S_SMUL;
        end else if (!waiting) begin
          cmd.op       = flas_pkg::OP_DDIV_GO;
          waiting_next = 1'b1;
        end else if (status.div_done) begin
          cmd.op       = flas_pkg::OP_DSET;
          waiting_next = 1'b0;
          state_next   = S_SMUL;
        end
      end
      S_SMUL: begin
        if (status.clamp) begin
          cmd.op     = flas_pkg::OP_SMUL;
          state_next = S_SDIV;
        end else begin
          cmd.op = flas_pkg::OP_SSET;
          if (idx == 2'd2) begin
            state_next = S_OUT;
          end else begin
            idx_next   = idx + 1'b1;
            state_next = S_DDIV;
          end
        end
      end
      S_SDIV: begin
        if (!waiting) begin
          cmd.op       = flas_pkg::OP_SDIV_GO;
          waiting_next = 1'b1;
        end else if (status.div_done) begin
          cmd.op       = flas_pkg::OP_SSET;
          waiting_next = 1'b0;
          if (idx == 2'd2) begin
            state_next = S_OUT;
          end else begin
            idx_next   = idx + 1'b1;
            state_next = S_DDIV;
          end
        end
      end
      S_OUT: begin
        if (status.out_free) begin
          cmd.op     = flas_pkg::OP_OUT;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next   = S_IDLE;
        waiting_next = 1'b0;
      end
    endcase
  end

endmodule

// ----- hw/rtl/flas_checker.sv -----
// Port-level checks for the alignment steering block and their binding to the top level.
`timescale 1ns / 1ps

module flas_checker (
  input logic                             clk,
  input logic                             rst,
  input logic                             in_valid,
  input logic                             in_ready,
  input flas_pkg::in_t                    in_data,
  input logic                             out_valid,
  input logic                             out_ready,
  input flas_pkg::out_t                   out_data,
  input logic                             cfg_valid,
  input logic                             cfg_ready
);

  // A waiting result is held until its transfer.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed or dropped before transfer");

  // Reset leaves no result pending.
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result pending after reset");

  // The block works on one item at a time.
  a_busy_after_take: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken again right after a transfer");

  // An item without last never produces a result on the next cycle.
  a_no_early_result: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && !in_data.last && !out_valid |=> !out_valid)
    else $error("result appeared without a last item");

  // Register writes are never stalled.
  a_cfg_open: assert property (@(posedge clk) disable iff (rst)
    cfg_valid |-> cfg_ready)
    else $error("configuration write stalled");

endmodule

bind flock_alignment_steer flas_checker u_flas_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data),
  .cfg_valid (cfg_valid),
  .cfg_ready (cfg_ready)
);

// ----- tb/tb_flock_alignment_steer.sv -----
// Self-checking testbench for the flocking alignment steering block.
`timescale 1ns / 1ps

module tb_flock_alignment_steer;

  localparam int MAX_NB = 256;
  localparam longint CYCLE_LIMIT = 2000000;
  localparam int SETTLE_CYCLES = 60;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  flas_pkg::in_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  flas_pkg::out_t out_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [flas_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [flas_pkg::CFG_DATA_W-1:0] cfg_data = '0;

  flock_alignment_steer #(.MAX_NEIGHBOURS(MAX_NB)) DUT (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  // Copy of the block's state and registers, updated on each accepted transfer.
  longint unsigned gain_reg = 64'(flas_pkg::GAIN_RESET);
  longint unsigned radius_reg = 64'(flas_pkg::RADIUS_RESET);
  longint signed own_pos [3] = '{0, 0, 0};
  longint unsigned own_limit = 0;
  longint signed vel_sum [3] = '{0, 0, 0};
  int near_count = 0;

  flas_pkg::out_t steer_expected [$];
  int errors = 0;
  longint cycles = 0;

  // Sender pacing and receiver hold-off control.
  int burst_left = 0;
  bit no_gaps = 1'b0;
  bit hold_req = 1'b0;
  int hold_left = 0;
  int pat_left = 0;
  int pat_mode = 0;

  // Sender-side view of the current query, used to place neighbours.
  logic signed [31:0] q_pos [3];

  function automatic longint unsigned int_sqrt(longint unsigned n);
    longint unsigned res, b;
    res = 0;
    b = 64'd1 << 62;
    while (b > n) b >>= 2;
    while (b != 0) begin
      if (n >= res + b) begin
        n -= res + b;
        res = (res >> 1) + b;
      end else begin
        res >>= 1;
      end
      b >>= 2;
    end
    return res;
  endfunction

  // Applies one item to the state; returns 1 with the steering result when last is set.
  function automatic bit steer_predict(input flas_pkg::in_t it, output flas_pkg::out_t r);
    logic signed [31:0] p [3];
    logic signed [31:0] v [3];
    longint unsigned ad, d2, q [3], u [3], m, n2, mg, lim, dv, st, dd;
    longint signed diff;
    bit nearb, over;
    bit neg [3];
    int sh;
    p = '{it.pos_x, it.pos_y, it.pos_z};
    v = '{it.vel_x, it.vel_y, it.vel_z};
    r = '0;
    if (it.cmd == flas_pkg::CMD_BEGIN) begin
      for (int i = 0; i < 3; i++) begin
        own_pos[i] = longint'(p[i]);
        vel_sum[i] = 0;
      end
      own_limit = 64'(it.speed_limit);
      near_count = 0;
    end else if (!it.is_self) begin
      nearb = 1'b1;
      d2 = 0;
      for (int i = 0; i < 3; i++) begin
        diff = own_pos[i] - longint'(p[i]);
        ad = diff < 0 ? -diff : diff;
        if (ad > radius_reg) nearb = 1'b0;
        else d2 += ad * ad;
      end
      if (nearb && d2 <= radius_reg * radius_reg && near_count < MAX_NB) begin
        for (int i = 0; i < 3; i++) vel_sum[i] += longint'(v[i]);
        near_count++;
      end
    end
    if (!it.last) return 1'b0;

    // Scale the sums, normalize, then derive the direction and the clamped velocity.
    dv = 64'(256 * (near_count + 1));
    m = 0;
    for (int i = 0; i < 3; i++) begin
      neg[i] = vel_sum[i] < 0;
      ad = neg[i] ? -vel_sum[i] : vel_sum[i];
      q[i] = ad * gain_reg / dv;
      if (q[i] > m) m = q[i];
    end
    sh = 0;
    while ((m >> sh) >= (64'd1 << 31)) sh++;
    n2 = 0;
    for (int i = 0; i < 3; i++) begin
      u[i] = q[i] >> sh;
      n2 += u[i] * u[i];
    end
    mg = int_sqrt(n2);
    lim = own_limit;
    over = (m > lim) || (n2 > lim * lim);
    for (int i = 0; i < 3; i++) begin
      dd = 0;
      if (mg != 0) begin
        dd = (u[i] << 15) / mg;
        if (dd > 32767) dd = 32767;
      end
      st = (over && mg != 0) ? u[i] * lim / mg : (over ? 0 : q[i]);
      if (neg[i]) begin
        st = -st;
        dd = -dd;
      end
      case (i)
        0: begin r.steer_x = st[31:0]; r.dir_x = dd[15:0]; end
        1: begin r.steer_y = st[31:0]; r.dir_y = dd[15:0]; end
        default: begin r.steer_z = st[31:0]; r.dir_z = dd[15:0]; end
      endcase
    end
    return 1'b1;
  endfunction

  // Cycle counter and timeout.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // Receiver: random stall pattern, with a long hold-off when requested.
  always @(posedge clk) begin
    if (hold_req) begin
      hold_left = 3000;
      hold_req = 1'b0;
    end
    if (rst) begin
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      if (pat_left == 0) begin
        pat_mode = $urandom_range(0, 2);
        pat_left = $urandom_range(20, 300);
      end
      pat_left--;
      case (pat_mode)
        0: out_ready <= 1'b1;
        1: out_ready <= 1'($urandom_range(0, 1));
        default: out_ready <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  task automatic report(input string name, input longint e, input longint a);
    if (e != a) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, e, a);
      errors++;
    end
  endtask

  // Result checker: every result transfer against the oldest expectation.
  always @(posedge clk) begin
    flas_pkg::out_t e;
    if (!rst && out_valid && out_ready) begin
      if (steer_expected.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %h", $time, out_data);
        errors++;
      end else begin
        e = steer_expected.pop_front();
        report("steer_x", e.steer_x, out_data.steer_x);
        report("steer_y", e.steer_y, out_data.steer_y);
        report("steer_z", e.steer_z, out_data.steer_z);
        report("dir_x", e.dir_x, out_data.dir_x);
        report("dir_y", e.dir_y, out_data.dir_y);
        report("dir_z", e.dir_z, out_data.dir_z);
      end
    end
  end

  // Sends one item; entered and left at a rising edge.
  task automatic send_item(input flas_pkg::in_t it);
    flas_pkg::out_t r;
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 20);
      gap = ($urandom_range(0, 1) == 0 || no_gaps) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    in_data <= it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (steer_predict(it, r)) steer_expected.push_back(r);
  endtask

  // Lets the block drain so that registers can be written.
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (steer_expected.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [flas_pkg::CFG_IDX_W-1:0] idx, input logic [31:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (idx == flas_pkg::REG_ALIGN_GAIN) gain_reg = 64'(val[15:0]);
    else if (idx == flas_pkg::REG_NEIGHBOUR_RADIUS) radius_reg = 64'(val[30:0]);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [31:0] rand_vel();
    case ($urandom_range(0, 4))
      0: return $urandom;
      1: return 32'h8000_0000;
      2: return 32'h7fff_ffff;
      3: return 0;
      default: return $urandom_range(0, 32'h1f_ffff) - 32'h10_0000;
    endcase
  endfunction

  function automatic logic [30:0] rand_limit();
    case ($urandom_range(0, 3))
      0: return 31'd0;
      1: return 31'($urandom_range(1, 32'h10_0000));
      2: return 31'h7fff_ffff;
      default: return 31'($urandom);
    endcase
  endfunction

  function automatic flas_pkg::in_t mk_begin(input bit lst);
    flas_pkg::in_t it;
    it = '0;
    it.cmd = flas_pkg::CMD_BEGIN;
    it.pos_x = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 32'hfffff) - 32'h80000;
    it.pos_y = $urandom;
    it.pos_z = $urandom_range(0, 32'hfffff) - 32'h80000;
    it.vel_x = $urandom;
    it.vel_y = $urandom;
    it.vel_z = $urandom;
    it.speed_limit = rand_limit();
    it.is_self = 1'($urandom_range(0, 1));
    it.last = lst;
    q_pos = '{it.pos_x, it.pos_y, it.pos_z};
    return it;
  endfunction

  // Neighbour around the current query position; mostly within the radius.
  function automatic flas_pkg::in_t mk_neighbour(input bit lst);
    flas_pkg::in_t it;
    logic signed [31:0] p [3];
    longint unsigned span;
    span = ($urandom_range(0, 4) == 0) ? radius_reg * 2 : radius_reg / 2;
    if (span > 32'h7fff_ffff) span = 32'h7fff_ffff;
    for (int i = 0; i < 3; i++) begin
      p[i] = q_pos[i] + ($urandom_range(0, 1) ? 32'sd1 : -32'sd1) *
             $signed({1'b0, 31'($urandom_range(0, 32'(span)))});
    end
    if ($urandom_range(0, 9) == 0) p[0] = $urandom;
    it = '0;
    it.cmd = flas_pkg::CMD_NEIGHBOUR;
    it.pos_x = p[0];
    it.pos_y = p[1];
    it.pos_z = p[2];
    it.vel_x = rand_vel();
    it.vel_y = rand_vel();
    it.vel_z = rand_vel();
    it.speed_limit = 31'($urandom);
    it.is_self = ($urandom_range(0, 7) == 0);
    it.last = lst;
    return it;
  endfunction

  // Extremes of the fields, both commands and the named corner cases.
  task automatic test_directed();
    flas_pkg::in_t it;
    // A neighbour before any begin uses the reset state.
    it = '0;
    it.cmd = flas_pkg::CMD_NEIGHBOUR;
    it.vel_x = 32'h7fff_ffff;
    it.vel_y = 32'h8000_0000;
    it.vel_z = 32'h0001_0000;
    it.last = 1'b1;
    send_item(it);
    // Begin with x and y at the most negative value and z at the most positive, maximum limit.
    it = '0;
    it.cmd = flas_pkg::CMD_BEGIN;
    it.pos_x = 32'h8000_0000;
    it.pos_y = 32'h8000_0000;
    it.pos_z = 32'h7fff_ffff;
    it.speed_limit = 31'h7fff_ffff;
    send_item(it);
    q_pos = '{it.pos_x, it.pos_y, it.pos_z};
    // Same position, extreme velocity; a self record; a far record.
    it.cmd = flas_pkg::CMD_NEIGHBOUR;
    it.vel_x = 32'h8000_0000;
    it.vel_y = 32'h7fff_ffff;
    it.vel_z = 32'hffff_ffff;
    send_item(it);
    it.is_self = 1'b1;
    send_item(it);
    it.is_self = 1'b0;
    it.pos_x = 32'h7fff_ffff;
    send_item(it);
    // Exactly on the radius along one axis, then the result.
    it.pos_x = 32'h8000_0000 + flas_pkg::RADIUS_RESET;
    it.vel_x = 32'h0002_0000;
    it.last = 1'b1;
    send_item(it);
    // Sums keep accumulating after a result.
    it.last = 1'b1;
    send_item(it);
    // Last on begin.
    it = mk_begin(1'b1);
    send_item(it);
    // Zero limit clamps a nonzero velocity to zero steer.
    it = mk_begin(1'b0);
    it.speed_limit = '0;
    send_item(it);
    q_pos = '{it.pos_x, it.pos_y, it.pos_z};
    send_item(mk_neighbour(1'b0));
    it = mk_neighbour(1'b1);
    it.pos_x = q_pos[0];
    it.pos_y = q_pos[1];
    it.pos_z = q_pos[2];
    it.is_self = 1'b0;
    it.vel_x = 32'h0003_0000;
    send_item(it);
    // Small limit with a large velocity.
    it = mk_begin(1'b0);
    it.speed_limit = 31'd1;
    send_item(it);
    it = mk_neighbour(1'b1);
    it.pos_x = q_pos[0];
    it.pos_y = q_pos[1];
    it.pos_z = q_pos[2];
    it.is_self = 1'b0;
    it.vel_x = 32'h7fff_ffff;
    it.vel_y = 32'h7fff_ffff;
    it.vel_z = 32'h7fff_ffff;
    send_item(it);
  endtask

  // The neighbour count saturates at its bound.
  task automatic test_count_bound();
    flas_pkg::in_t it;
    it = mk_begin(1'b0);
    it.speed_limit = 31'h7fff_ffff;
    send_item(it);
    for (int k = 0; k < MAX_NB + 4; k++) begin
      it = mk_neighbour(k == MAX_NB + 3);
      it.pos_x = q_pos[0];
      it.pos_y = q_pos[1];
      it.pos_z = q_pos[2];
      it.is_self = 1'b0;
      it.vel_x = $urandom_range(0, 32'h3_ffff);
      send_item(it);
    end
  endtask

  // Receiver holds off while queries keep arriving, so the input stalls.
  task automatic test_backpressure();
    hold_req = 1'b1;
    no_gaps = 1'b1;
    for (int k = 0; k < 8; k++) begin
      send_item(mk_begin(1'b0));
      send_item(mk_neighbour(1'b1));
    end
    no_gaps = 1'b0;
  endtask

  // Mostly well-formed queries, with some stray items in between.
  task automatic test_random(input int n);
    int sent, k;
    sent = 0;
    while (sent < n) begin
      if ($urandom_range(0, 6) != 0) begin
        k = $urandom_range(0, 6);
        send_item(mk_begin(k == 0));
        sent++;
        for (int j = 1; j <= k; j++) begin
          send_item(mk_neighbour(j == k));
          sent++;
        end
      end else begin
        send_item($urandom_range(0, 1) ? mk_neighbour($urandom_range(0, 1)) : mk_begin(1'b1));
        sent++;
      end
    end
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_random(120);
    settle();
    cfg_write(flas_pkg::REG_ALIGN_GAIN, 32'd0);
    cfg_write(flas_pkg::REG_NEIGHBOUR_RADIUS, 32'd0);
    test_random(50);
    settle();
    cfg_write(flas_pkg::REG_ALIGN_GAIN, 32'hffff);
    cfg_write(flas_pkg::REG_NEIGHBOUR_RADIUS, 32'h7fff_ffff);
    test_random(120);
    test_backpressure();
    settle();
    cfg_write(flas_pkg::REG_ALIGN_GAIN, $urandom_range(1, 32'hffff));
    cfg_write(flas_pkg::REG_NEIGHBOUR_RADIUS, $urandom_range(32'h1_0000, 32'h100_0000));
    test_count_bound();
    test_random(110);
    settle();
    cfg_write(flas_pkg::REG_ALIGN_GAIN, 32'd256);
    cfg_write(flas_pkg::REG_NEIGHBOUR_RADIUS, $urandom);
    test_random(110);
    settle();
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
